>>> design/hpq_pkg.sv
// Shared types, codes and defaults for the max-heap priority queue.
`timescale 1ns / 1ps

package hpq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 32;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 7;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // latch request
      logic set_full;   // refuse insert
      logic set_empty;  // refuse remove
      logic ins_begin;  // grow count, hole at new last slot
      logic rem_begin;  // take root, read last slot, shrink count
      logic take_last;  // last entry becomes moving key
      logic rd_parent;
      logic up_move;    // parent moves down into hole
      logic rd_left;
      logic rd_right;
      logic take_left;
      logic dn_move;    // larger child moves up into hole
      logic wr_key;     // drop moving key into hole
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic func_remove;
      logic full;
      logic empty;
      logic at_root;
      logic left_in;
      logic parent_less;
      logic dn_swap;
   } sts_type;

endpackage

>>> design/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue of signed 32-bit keys.
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// request   start in, busy out    req_func, req_key_in
// response  rsp_strobe out        rsp_status, rsp_removed_key, rsp_top_valid,
//                                 rsp_top_key, rsp_entry_count
//
// A request is accepted when start is high and busy is low, and busy stays high until
// the response is issued. An insert reads and compares one parent per level the key
// climbs; a remove takes the root, reads the last entry, then reads both children and
// compares per level it sinks; refused requests go straight to the response.
// The heap RAM has a single read port, so entries are fetched one at a time.
// Reset clears the fill count and the controller; RAM contents need no clearing.
// The response strobe lasts one cycle and the receiver cannot stall it.

module max_heap_priority_queue #(
   parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_func,
   input  logic signed [hpq_pkg::KEY_W-1:0]   req_key_in,
   output logic                               rsp_strobe,
   output logic [hpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [hpq_pkg::KEY_W-1:0]   rsp_removed_key,
   output logic                               rsp_top_valid,
   output logic signed [hpq_pkg::KEY_W-1:0]   rsp_top_key,
   output logic [hpq_pkg::COUNT_OUT_W-1:0]    rsp_entry_count
);

   // Command and status between the sequencer and the datapath.
   hpq_pkg::cmd_type cmd;
   hpq_pkg::sts_type sts;

   // Sequence each request: decide, then walk the heap one level at a time.
   hpq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Hold the heap, the moving key and the hole; register the response.
   hpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_key_in      (req_key_in),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_removed_key (rsp_removed_key),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_top_key     (rsp_top_key),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

>>> design/hpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/hpq_ctrl.sv
// Controller state machine sequencing insert sift-up and remove sift-down.
`timescale 1ns / 1ps

module hpq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hpq_pkg::sts_type sts,
   output hpq_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DECIDE  = 9'b000000010,
      ST_UP_RD   = 9'b000000100,
      ST_UP_CMP  = 9'b000001000,
      ST_DN_LAST = 9'b000010000,
      ST_DN_RDL  = 9'b000100000,
      ST_DN_RDR  = 9'b001000000,
      ST_DN_CMP  = 9'b010000000,
      ST_RESP    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.func_remove) begin
               if (sts.empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  cmd.rem_begin = 1'b1;
                  state_in      = ST_DN_LAST;
               end
            end else begin
               if (sts.full) begin
                  cmd.set_full = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  cmd.ins_begin = 1'b1;
                  state_in      = ST_UP_RD;
               end
            end
         end
         ST_UP_RD: begin
            if (sts.at_root) begin
               cmd.wr_key = 1'b1;
               state_in   = ST_RESP;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (sts.parent_less) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_RD;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_DN_LAST: begin
            cmd.take_last = 1'b1;
            state_in      = ST_DN_RDL;
         end
         ST_DN_RDL: begin
            if (sts.left_in) begin
               cmd.rd_left = 1'b1;
               state_in    = ST_DN_RDR;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_DN_RDR: begin
            cmd.take_left = 1'b1;
            cmd.rd_right  = 1'b1;
            state_in      = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (sts.dn_swap) begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_RDL;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef ASSERT_OFF
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start work");

   a_respond_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("controller still busy after response");
`endif

endmodule

>>> design/hpq_dp.sv
// Datapath: heap RAM, moving key, hole position, fill count and result registers.
`timescale 1ns / 1ps

module hpq_dp #(
   parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_func,
   input  logic signed [hpq_pkg::KEY_W-1:0]   req_key_in,
   input  hpq_pkg::cmd_type                   cmd,
   output hpq_pkg::sts_type                   sts,
   output logic                               rsp_strobe,
   output logic [hpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [hpq_pkg::KEY_W-1:0]   rsp_removed_key,
   output logic                               rsp_top_valid,
   output logic signed [hpq_pkg::KEY_W-1:0]   rsp_top_key,
   output logic [hpq_pkg::COUNT_OUT_W-1:0]    rsp_entry_count
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SLOT_W = $clog2(2 * CAPACITY + 2);
   localparam int KW     = hpq_pkg::KEY_W;
   localparam int OW     = hpq_pkg::COUNT_OUT_W;

   logic                           func_ff;
   logic signed [KW-1:0]           key_ff, key_in;
   logic signed [KW-1:0]           lval_ff;
   logic signed [KW-1:0]           root_ff;
   logic [SLOT_W-1:0]              pos_ff, pos_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [hpq_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic signed [KW-1:0]           removed_ff, removed_in;

   logic                           strobe_ff;
   logic [hpq_pkg::STATUS_W-1:0]   out_status_ff;
   logic signed [KW-1:0]           out_removed_ff;
   logic                           out_valid_ff;
   logic signed [KW-1:0]           out_top_ff;
   logic [OW-1:0]                  out_count_ff;

   logic [SLOT_W-1:0]              count_ext, parent, lc, rc, rd_slot, dn_slot;
   logic                           right_in, pick_left, pick_right;
   logic signed [KW-1:0]           best_l, dn_val, rd_data, wr_data;
   logic                           wr_en, rd_en;
   logic [CNT_W+OW-1:0]            cnt_wide;

   assign count_ext = SLOT_W'(count_ff);
   assign parent    = pos_ff >> 1;
   assign lc        = {pos_ff[SLOT_W-2:0], 1'b0};
   assign rc        = lc | SLOT_W'(1);
   assign right_in  = (rc <= count_ext);

   // Larger-child selection; strict compares keep the left child on ties.
   assign pick_left  = (key_ff < lval_ff);
   assign best_l     = pick_left ? lval_ff : key_ff;
   assign pick_right = right_in && (best_l < rd_data);
   assign dn_slot    = pick_right ? rc : lc;
   assign dn_val     = pick_right ? rd_data : lval_ff;

   assign sts.func_remove = (func_ff == hpq_pkg::FUNC_REMOVE);
   assign sts.full        = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty       = (count_ff == '0);
   assign sts.at_root     = (pos_ff == SLOT_W'(1));
   assign sts.left_in     = (lc <= count_ext);
   assign sts.parent_less = (rd_data < key_ff);
   assign sts.dn_swap     = pick_left || pick_right;

   always_comb begin
      rd_slot = parent;
      if (cmd.rem_begin) begin
         rd_slot = count_ext;
      end else if (cmd.rd_left) begin
         rd_slot = lc;
      end else if (cmd.rd_right) begin
         rd_slot = rc;
      end
   end

   assign rd_en   = cmd.rem_begin || cmd.rd_parent || cmd.rd_left ||
                    (cmd.rd_right && right_in);
   assign wr_en   = cmd.wr_key || cmd.up_move || cmd.dn_move;
   assign wr_data = cmd.up_move ? rd_data : (cmd.dn_move ? dn_val : key_ff);

   hpq_ram #(
      .WIDTH (KW),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(pos_ff - SLOT_W'(1))),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(rd_slot - SLOT_W'(1))),
      .rd_data (rd_data)
   );

   always_comb begin
      key_in     = key_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      if (cmd.load) begin
         key_in = req_key_in;
      end
      if (cmd.set_full) begin
         status_in  = hpq_pkg::STATUS_FULL;
         removed_in = '0;
      end
      if (cmd.set_empty) begin
         status_in  = hpq_pkg::STATUS_EMPTY;
         removed_in = '0;
      end
      if (cmd.ins_begin) begin
         status_in  = hpq_pkg::STATUS_OK;
         removed_in = '0;
         count_in   = count_ff + CNT_W'(1);
         pos_in     = count_ext + SLOT_W'(1);
      end
      if (cmd.rem_begin) begin
         status_in  = hpq_pkg::STATUS_OK;
         removed_in = root_ff;
         count_in   = count_ff - CNT_W'(1);
         pos_in     = SLOT_W'(1);
      end
      if (cmd.take_last) begin
         key_in = rd_data;
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.dn_move) begin
         pos_in = dn_slot;
      end
   end

   assign cnt_wide = {{OW{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      pos_ff     <= pos_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (cmd.load) begin
         func_ff <= req_func;
      end
      if (cmd.take_left) begin
         lval_ff <= rd_data;
      end
      if (wr_en && (pos_ff == SLOT_W'(1))) begin
         root_ff <= wr_data;
      end
      if (cmd.respond) begin
         out_status_ff  <= status_ff;
         out_removed_ff <= removed_ff;
         out_valid_ff   <= (count_ff != '0);
         out_top_ff     <= (count_ff != '0) ? root_ff : '0;
         out_count_ff   <= cnt_wide[OW-1:0];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_removed_key = out_removed_ff;
   assign rsp_top_valid   = out_valid_ff;
   assign rsp_top_key     = out_top_ff;
   assign rsp_entry_count = out_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_read_in_heap: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_slot >= SLOT_W'(1)) && (rd_slot <= count_ext))
      else $error("read outside the filled part of the heap");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (count_ff != '0)) |-> (pos_ff >= SLOT_W'(1)) && (pos_ff <= count_ext))
      else $error("write outside the filled part of the heap");
`endif

endmodule

>>> bench/max_heap_priority_queue_tb.sv
// Self-checking bench for the max-heap priority queue: directed corner cases, then random bursts.
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;

   localparam int HEAP_DEPTH   = hpq_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 880;
   // No request accepted and no response seen for this many cycles means a hang.
   localparam int STALL_LIMIT  = 2000;
   // Drain time after the last response before the verdict.
   localparam int TAIL_CYCLES  = 40;

   typedef logic signed [hpq_pkg::KEY_W-1:0] key_type;

   // One predicted response.
   typedef struct {
      logic [hpq_pkg::STATUS_W-1:0]    status;
      key_type                         removed_key;
      logic                            top_valid;
      key_type                         top_key;
      logic [hpq_pkg::COUNT_OUT_W-1:0] entry_count;
   } heap_reply_type;

   // Scoreboard: holds its own copy of the heap and the responses still owed.
   class heap_scoreboard;
      key_type        slot[HEAP_DEPTH + 1];   // 1-based, slot 0 unused
      int unsigned    fill;
      heap_reply_type owed_replies[$];
      int             mismatch_count;

      function void clear_heap();
         fill = 0;
         owed_replies.delete();
         mismatch_count = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         key_type hold;
         hold    = slot[a];
         slot[a] = slot[b];
         slot[b] = hold;
      endfunction

      // Apply one accepted request to the heap copy and queue the response it owes.
      function void note_request(logic op, key_type key);
         heap_reply_type rep;
         int unsigned pos;
         int unsigned best;
         rep.status      = hpq_pkg::STATUS_OK;
         rep.removed_key = '0;
         if (op == hpq_pkg::FUNC_INSERT) begin
            if (fill >= HEAP_DEPTH) begin
               rep.status = hpq_pkg::STATUS_FULL;
            end else begin
               fill++;
               slot[fill] = key;
               pos = fill;
               // climb while strictly greater than the parent
               while (pos > 1 && slot[pos >> 1] < slot[pos]) begin
                  swap_slots(pos >> 1, pos);
                  pos = pos >> 1;
               end
            end
         end else begin
            if (fill == 0) begin
               rep.status = hpq_pkg::STATUS_EMPTY;
            end else begin
               rep.removed_key = slot[1];
               slot[1] = slot[fill];
               fill--;
               pos = 1;
               // sink toward the larger child; left wins a tie
               forever begin
                  best = pos;
                  if (2 * pos <= fill && slot[best] < slot[2 * pos])
                     best = 2 * pos;
                  if (2 * pos + 1 <= fill && slot[best] < slot[2 * pos + 1])
                     best = 2 * pos + 1;
                  if (best == pos)
                     break;
                  swap_slots(pos, best);
                  pos = best;
               end
            end
         end
         rep.top_valid   = (fill > 0);
         rep.top_key     = (fill > 0) ? slot[1] : '0;
         rep.entry_count = fill[hpq_pkg::COUNT_OUT_W-1:0];
         owed_replies.push_back(rep);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         mismatch_count++;
         $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
      endtask

      task check_response(logic [hpq_pkg::STATUS_W-1:0] status, key_type removed_key,
                          logic top_valid, key_type top_key,
                          logic [hpq_pkg::COUNT_OUT_W-1:0] entry_count);
         heap_reply_type want;
         if (owed_replies.size() == 0) begin
            report_mismatch("response with no request pending", 64'(status), 64'd0);
         end else begin
            want = owed_replies.pop_front();
            if (status !== want.status)
               report_mismatch("status", 64'(status), 64'(want.status));
            if (removed_key !== want.removed_key)
               report_mismatch("removed_key", 64'(removed_key), 64'(want.removed_key));
            if (top_valid !== want.top_valid)
               report_mismatch("top_valid", 64'(top_valid), 64'(want.top_valid));
            if (top_key !== want.top_key)
               report_mismatch("top_key", 64'(top_key), 64'(want.top_key));
            if (entry_count !== want.entry_count)
               report_mismatch("entry_count", 64'(entry_count), 64'(want.entry_count));
         end
      endtask

      function int pending();
         return owed_replies.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic                            req_func;
   key_type                         req_key_in;
   logic                            rsp_strobe;
   logic [hpq_pkg::STATUS_W-1:0]    rsp_status;
   key_type                         rsp_removed_key;
   logic                            rsp_top_valid;
   key_type                         rsp_top_key;
   logic [hpq_pkg::COUNT_OUT_W-1:0] rsp_entry_count;

   heap_scoreboard sb;
   int             stall_cycles;

   max_heap_priority_queue #(
      .CAPACITY (HEAP_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key_in      (req_key_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_removed_key (rsp_removed_key),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_top_key     (rsp_top_key),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Check every response in the cycle its strobe is up; values seen here
   // are the ones present just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_response(rsp_status, rsp_removed_key, rsp_top_valid, rsp_top_key,
                           rsp_entry_count);
   end

   // Watchdog: count cycles with no handshake of any kind; give up at the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Send one request. Call right after a rising edge; returns at the edge that
   // accepted it. With a zero gap, start stays high straight into the next request.
   task automatic issue(input logic op, input key_type key, input bit no_idle);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_func   <= op;
      req_key_in <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(op, key);
   endtask

   // Mostly full-range keys, with a share of tiny keys to force ties and
   // a share of the two extremes.
   function automatic key_type pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return key_type'($urandom);
      else if (roll < 85)
         return key_type'($urandom_range(0, 7)) - key_type'(3);
      else if (roll < 93)
         return {1'b0, {(hpq_pkg::KEY_W-1){1'b1}}};
      else
         return {1'b1, {(hpq_pkg::KEY_W-1){1'b0}}};
   endfunction

   initial begin
      int   sent;
      int   burst_len;
      int   insert_pct;
      bit   no_idle;
      logic op;

      sb = new;
      sb.clear_heap();
      stall_cycles = 0;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_func   <= hpq_pkg::FUNC_INSERT;
      req_key_in <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: remove on an empty heap, extreme keys, ties, drain past empty.
      issue(hpq_pkg::FUNC_REMOVE, key_type'(32'h1234_5678), 1'b0);
      issue(hpq_pkg::FUNC_INSERT, key_type'(0), 1'b0);
      issue(hpq_pkg::FUNC_INSERT, {1'b0, {(hpq_pkg::KEY_W-1){1'b1}}}, 1'b1);
      issue(hpq_pkg::FUNC_INSERT, {1'b1, {(hpq_pkg::KEY_W-1){1'b0}}}, 1'b1);
      issue(hpq_pkg::FUNC_INSERT, key_type'(-1), 1'b0);
      issue(hpq_pkg::FUNC_INSERT, key_type'(1), 1'b0);
      issue(hpq_pkg::FUNC_INSERT, key_type'(5), 1'b1);
      issue(hpq_pkg::FUNC_INSERT, key_type'(5), 1'b1);
      issue(hpq_pkg::FUNC_INSERT, key_type'(5), 1'b0);
      issue(hpq_pkg::FUNC_REMOVE, key_type'(-1), 1'b0);
      issue(hpq_pkg::FUNC_REMOVE, key_type'(0), 1'b1);
      issue(hpq_pkg::FUNC_INSERT, {1'b1, {(hpq_pkg::KEY_W-1){1'b0}}}, 1'b0);
      issue(hpq_pkg::FUNC_INSERT, key_type'(5), 1'b0);
      repeat (9) issue(hpq_pkg::FUNC_REMOVE, key_type'($urandom), 1'b0);
      issue(hpq_pkg::FUNC_REMOVE, key_type'(0), 1'b1);

      // Random bursts: fill toward full, drain toward empty, or mix.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 90;
            1:       insert_pct = 12;
            default: insert_pct = 50;
         endcase
         burst_len = $urandom_range(40, 120);
         if (burst_len > RANDOM_ITEMS - sent)
            burst_len = RANDOM_ITEMS - sent;
         no_idle   = ($urandom_range(0, 3) == 0);
         repeat (burst_len) begin
            op = ($urandom_range(0, 99) < insert_pct) ? hpq_pkg::FUNC_INSERT
                                                      : hpq_pkg::FUNC_REMOVE;
            issue(op, (op == hpq_pkg::FUNC_INSERT) ? pick_key() : key_type'($urandom),
                  no_idle);
            sent++;
         end
      end
      start <= 1'b0;

      // Hold until every owed response has come, then let the block settle.
      while (sb.pending() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
